// ===== design/copg_pkg.sv =====
// Shared types and constants for the circle outline point generator.
package copg_pkg;

	localparam int unsigned CENTER_W   = 10;
	localparam int unsigned RADIUS_W   = 6;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned OX_W       = 7;
	localparam int unsigned OY_W       = 8;
	localparam int unsigned DEC_W      = 9;
	localparam int unsigned CALC_W     = 10;
	localparam int unsigned COORD_BITS = 10;
	localparam int unsigned MAX_RESULTS = 64;
	localparam int unsigned CNT_W      = $clog2(MAX_RESULTS);

	localparam logic [RADIUS_W-1:0] MAX_RADIUS  = RADIUS_W'(62);
	localparam logic [CENTER_W-1:0] CENTER_MASK = CENTER_W'((32'd1 << COORD_BITS) - 32'd1);
	localparam logic [CNT_W-1:0]    LAST_CNT    = CNT_W'(MAX_RESULTS - 1);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] right_x_near;
		logic signed [COORD_W-1:0] left_x_near;
		logic signed [COORD_W-1:0] right_x_far;
		logic signed [COORD_W-1:0] left_x_far;
		logic signed [COORD_W-1:0] lower_y_far;
		logic signed [COORD_W-1:0] upper_y_far;
		logic signed [COORD_W-1:0] lower_y_near;
		logic signed [COORD_W-1:0] upper_y_near;
		logic                      last_step;
	} point_res_t;

endpackage

// ===== design/copg_if.sv =====
// Channel interfaces: circle request in, outline point set out.
interface copg_circle_if;
	logic                                valid;
	logic                                ready;
	logic [copg_pkg::CENTER_W-1:0]       center_x;
	logic [copg_pkg::CENTER_W-1:0]       center_y;
	logic [copg_pkg::RADIUS_W-1:0]       circle_radius;

	modport source (output valid, output center_x, output center_y, output circle_radius,
		input ready);
	modport sink (input valid, input center_x, input center_y, input circle_radius,
		output ready);
endinterface

interface copg_points_if;
	logic                                valid;
	logic                                ready;
	logic signed [copg_pkg::COORD_W-1:0] right_x_near;
	logic signed [copg_pkg::COORD_W-1:0] left_x_near;
	logic signed [copg_pkg::COORD_W-1:0] right_x_far;
	logic signed [copg_pkg::COORD_W-1:0] left_x_far;
	logic signed [copg_pkg::COORD_W-1:0] lower_y_far;
	logic signed [copg_pkg::COORD_W-1:0] upper_y_far;
	logic signed [copg_pkg::COORD_W-1:0] lower_y_near;
	logic signed [copg_pkg::COORD_W-1:0] upper_y_near;
	logic                                last_step;

	modport source (output valid, output right_x_near, output left_x_near,
		output right_x_far, output left_x_far, output lower_y_far, output upper_y_far,
		output lower_y_near, output upper_y_near, output last_step, input ready);
	modport sink (input valid, input right_x_near, input left_x_near,
		input right_x_far, input left_x_far, input lower_y_far, input upper_y_far,
		input lower_y_near, input upper_y_near, input last_step, output ready);
endinterface

// ===== design/copg_ctrl.sv =====
// Run controller: accepts a circle, sequences the steps, owns output valid.
module copg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output copg_pkg::ctrl_cmd_t  cmd,
	input  copg_pkg::dp_status_t status
);
	import copg_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (slot_free) begin
					cmd.step = 1'b1;
					if (status.last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/copg_datapath.sv =====
// Step datapath: offset/decision registers, update rule, result register.
module copg_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  copg_pkg::ctrl_cmd_t           cmd,
	output copg_pkg::dp_status_t          status,
	input  logic [copg_pkg::CENTER_W-1:0] center_x,
	input  logic [copg_pkg::CENTER_W-1:0] center_y,
	input  logic [copg_pkg::RADIUS_W-1:0] circle_radius,
	output copg_pkg::point_res_t          result
);
	import copg_pkg::*;

	logic        [CENTER_W-1:0] cx_q, cy_q;
	logic        [RADIUS_W-1:0] r_q;
	logic        [OX_W-1:0]     ox_q;
	logic signed [OY_W-1:0]     oy_q;
	logic signed [DEC_W-1:0]    d_q;
	logic        [CNT_W-1:0]    cnt_q;
	point_res_t                 res_q;

	logic        [RADIUS_W-1:0] r_sat;
	logic signed [CALC_W-1:0]   ox_e, oy_e, d_e, r_e, two_ox, d_nxt;
	logic        [OX_W-1:0]     ox_nxt;
	logic signed [OY_W-1:0]     oy_nxt;
	logic                       last;
	logic        [COORD_W-1:0]  cx_c, cy_c, ox_c, oy_c;

	assign r_sat = (circle_radius > MAX_RADIUS) ? MAX_RADIUS : circle_radius;

	assign ox_e   = {{(CALC_W-OX_W){1'b0}}, ox_q};
	assign oy_e   = {{(CALC_W-OY_W){oy_q[OY_W-1]}}, oy_q};
	assign d_e    = {{(CALC_W-DEC_W){d_q[DEC_W-1]}}, d_q};
	assign r_e    = {{(CALC_W-RADIUS_W){1'b0}}, r_q};
	assign two_ox = ox_e <<< 1;

	// Three-way update: x step, y step, or diagonal step
	always_comb begin
		ox_nxt = ox_q;
		oy_nxt = oy_q;
		priority if (d_e >= two_ox) begin
			d_nxt  = d_e - two_ox - CALC_W'(1);
			ox_nxt = ox_q + OX_W'(1);
		end else if (d_e < ((r_e - oy_e) <<< 1)) begin
			d_nxt  = d_e + (oy_e <<< 1) - CALC_W'(1);
			oy_nxt = oy_q - OY_W'(1);
		end else begin
			d_nxt  = d_e + ((oy_e - ox_e - CALC_W'(1)) <<< 1);
			oy_nxt = oy_q - OY_W'(1);
			ox_nxt = ox_q + OX_W'(1);
		end
	end

	assign last = ($signed({oy_nxt[OY_W-1], oy_nxt}) < $signed({2'b00, ox_nxt}))
		|| (cnt_q == LAST_CNT);
	assign status.last = last;

	assign cx_c = {{(COORD_W-CENTER_W){1'b0}}, cx_q};
	assign cy_c = {{(COORD_W-CENTER_W){1'b0}}, cy_q};
	assign ox_c = {{(COORD_W-OX_W){1'b0}}, ox_q};
	assign oy_c = {{(COORD_W-OY_W){oy_q[OY_W-1]}}, oy_q};

	// Loop state: every run starts with a load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			r_q   <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			d_q   <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			cx_q  <= center_x & CENTER_MASK;
			cy_q  <= center_y & CENTER_MASK;
			r_q   <= r_sat;
			ox_q  <= '0;
			oy_q  <= {{(OY_W-RADIUS_W){1'b0}}, r_sat};
			d_q   <= DEC_W'({{(DEC_W-RADIUS_W){1'b0}}, r_sat}) - DEC_W'(1);
			cnt_q <= '0;
		end else if (cmd.step) begin
			ox_q  <= ox_nxt;
			oy_q  <= oy_nxt;
			d_q   <= d_nxt[DEC_W-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (cmd.step) begin
			res_q.right_x_near <= cx_c + ox_c;
			res_q.left_x_near  <= cx_c - ox_c;
			res_q.right_x_far  <= cx_c + oy_c;
			res_q.left_x_far   <= cx_c - oy_c;
			res_q.lower_y_far  <= cy_c + oy_c;
			res_q.upper_y_far  <= cy_c - oy_c;
			res_q.lower_y_near <= cy_c + ox_c;
			res_q.upper_y_near <= cy_c - ox_c;
			res_q.last_step    <= last;
		end
	end

	assign result = res_q;

endmodule

// ===== design/circle_outline_point_generator_unit.sv =====
// Top level: Andres circle outline point generator.
//
// circle (sink): one transaction carries center_x, center_y and circle_radius.
// points (source): one transaction per loop step with the eight symmetric
//   points as four x and four y coordinates; last_step marks the final one.
// A radius above 62 is clamped to 62; radius 0 gives a single point set at
//   the centre with last_step set.
// Timing: the circle is first loaded into the step registers, then the shared
//   step unit makes one point set per cycle while the receiver takes every
//   set; each step writes its set into the output register. A circle gives
//   one set per pixel of its first octant arc (51 sets for r = 62, never
//   more than 64).
// circle.ready is high only while no run is in progress; the next circle
//   may be taken while the last point set still waits in the output register.
// A receiver stall holds the output register and pauses the step unit; no
//   set is lost or repeated.
// Reset (arst_n low) returns the controller to idle, clears the step
//   registers and drops points.valid.
module circle_outline_point_generator_unit (
	input logic            clk,
	input logic            arst_n,
	copg_circle_if.sink    circle,
	copg_points_if.source  points
);
	import copg_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	point_res_t result;

	copg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (circle.valid),
		.in_ready  (circle.ready),
		.out_valid (points.valid),
		.out_ready (points.ready),
		.cmd       (cmd),
		.status    (status)
	);

	copg_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.center_x      (circle.center_x),
		.center_y      (circle.center_y),
		.circle_radius (circle.circle_radius),
		.result        (result)
	);

	assign points.right_x_near = result.right_x_near;
	assign points.left_x_near  = result.left_x_near;
	assign points.right_x_far  = result.right_x_far;
	assign points.left_x_far   = result.left_x_far;
	assign points.lower_y_far  = result.lower_y_far;
	assign points.upper_y_far  = result.upper_y_far;
	assign points.lower_y_near = result.lower_y_near;
	assign points.upper_y_near = result.upper_y_near;
	assign points.last_step    = result.last_step;

endmodule

// ===== design/copg_checker.sv =====
// Port-level checks for the circle outline point generator, bound to the top.
module copg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [copg_pkg::COORD_W-1:0] right_x_near,
	input logic signed [copg_pkg::COORD_W-1:0] left_x_far,
	input logic                                last_step
);

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(right_x_near)
		&& $stable(left_x_far) && $stable(last_step))
		else $error("output changed while stalled");

	// a taken circle starts a run: no second circle next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("circle taken while a run was starting");

	// the block only becomes ready again once the final set is presented
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid && last_step)
		else $error("ready returned without a final point set");

endmodule

bind circle_outline_point_generator_unit copg_checker u_copg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (circle.valid),
	.in_ready     (circle.ready),
	.out_valid    (points.valid),
	.out_ready    (points.ready),
	.right_x_near (points.right_x_near),
	.left_x_far   (points.left_x_far),
	.last_step    (points.last_step)
);
